// ----- hdl/key_matrix_debouncer_defines.svh -----
// ----------------------------------------------------------------------------
// key matrix debouncer assertion macros
// shared property forms for the port checker, clocked on clk, off in reset
// ----------------------------------------------------------------------------
`ifndef KEY_MATRIX_DEBOUNCER_DEFINES_SVH
`define KEY_MATRIX_DEBOUNCER_DEFINES_SVH

// same-cycle implication, consequent may carry a fixed delay
`define KMD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error(msg);

// next-cycle implication
`define KMD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/kmd_pkg.sv -----
// ----------------------------------------------------------------------------
// kmd_pkg
// shared constants and codes for the key matrix debouncer
// ----------------------------------------------------------------------------
`default_nettype none

package kmd_pkg;

  localparam int unsigned DEF_ROWS = 8;
  localparam int unsigned DEF_COLS = 8;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned POS_W      = 3;
  localparam int unsigned TIME_W     = 32;

  localparam logic [15:0] DEBOUNCE_RST = 16'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE = 4'd0,
    CFG_ROTATION = 4'd1,
    CFG_INV_VERT = 4'd2,
    CFG_INV_HORZ = 4'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_t;

endpackage

`default_nettype wire

// ----- hdl/key_matrix_debouncer.sv -----
// ----------------------------------------------------------------------------
// key_matrix_debouncer: per-key timestamp debounce with rotate and flip map
// a result passes through the input stage and then the result register to out_valid
// throughput: one item per cycle unless a stalled result holds the result register and the input stage
// reset: sync active-low rst_n clears all key levels, pending flags and valid flags, and resets the config regs
// ----------------------------------------------------------------------------
`default_nettype none

module key_matrix_debouncer #(
  parameter int unsigned ROWS = kmd_pkg::DEF_ROWS,
  parameter int unsigned COLS = kmd_pkg::DEF_COLS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // sampled keys
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [kmd_pkg::POS_W-1:0]        in_row,
  input  logic [kmd_pkg::POS_W-1:0]        in_col,
  input  logic                             in_raw_pressed,
  input  logic [kmd_pkg::TIME_W-1:0]       in_now_ms,
  // settled key events
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [kmd_pkg::POS_W-1:0]        out_row,
  output logic [kmd_pkg::POS_W-1:0]        out_col,
  output logic                             out_pressed,
  // register writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [kmd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [kmd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int unsigned KEYS   = ROWS * COLS;
  localparam int unsigned KW     = (KEYS > 1) ? $clog2(KEYS) : 1;
  localparam bit          SQUARE = (ROWS == COLS);
  localparam logic [5:0]  ROW_MAX = 6'(ROWS - 1);
  localparam logic [5:0]  COL_MAX = 6'(COLS - 1);

  function automatic logic [KW-1:0] key_of(input logic [kmd_pkg::POS_W-1:0] r,
                                           input logic [kmd_pkg::POS_W-1:0] c);
    key_of = KW'(32'(r) * COLS + 32'(c));
  endfunction

  // configuration
  logic [15:0] deb_r;
  logic [1:0]  rot_r;
  logic        inv_v_r;
  logic        inv_h_r;

  // input stage
  logic                       s1_valid_r;
  logic [kmd_pkg::POS_W-1:0]  s1_row_r;
  logic [kmd_pkg::POS_W-1:0]  s1_col_r;
  logic                       s1_raw_r;
  logic [kmd_pkg::TIME_W-1:0] s1_now_r;
  logic [kmd_pkg::TIME_W-1:0] s1_stamp_r;

  // per-key state
  logic [KEYS-1:0]            level_r;
  logic [KEYS-1:0]            pend_r;
  logic [kmd_pkg::TIME_W-1:0] stamp_mem [KEYS];

  // result register
  logic                       out_valid_r;
  logic [kmd_pkg::POS_W-1:0]  out_row_r;
  logic [kmd_pkg::POS_W-1:0]  out_col_r;
  logic                       out_pressed_r;

  logic                       in_fire;
  logic                       s1_adv;
  logic [KW-1:0]              in_key;
  logic [KW-1:0]              s1_key;
  logic                       s1_in_range;
  logic                       cur_level;
  logic                       cur_pend;
  logic                       changed;
  logic                       pend_any;
  logic [kmd_pkg::TIME_W-1:0] stamp_eff;
  logic [kmd_pkg::TIME_W-1:0] age;
  logic                       settled;
  logic                       stamp_wr;
  logic                       pend_nxt;
  logic                       out_valid_nxt;
  kmd_pkg::rot_t              rot_eff;
  logic [5:0]                 map_a;
  logic [5:0]                 map_b;
  logic [5:0]                 row6;
  logic [5:0]                 col6;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_r   <= kmd_pkg::DEBOUNCE_RST;
      rot_r   <= kmd_pkg::ROT_0;
      inv_v_r <= 1'b0;
      inv_h_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (kmd_pkg::cfg_idx_t'(cfg_index))
        kmd_pkg::CFG_DEBOUNCE: deb_r   <= cfg_wdata;
        kmd_pkg::CFG_ROTATION: rot_r   <= cfg_wdata[1:0];
        kmd_pkg::CFG_INV_VERT: inv_v_r <= cfg_wdata[0];
        kmd_pkg::CFG_INV_HORZ: inv_h_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // the input stage moves on whenever the result register is free or drained
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign in_key = key_of(in_row, in_col);
  assign s1_key = key_of(s1_row_r, s1_col_r);

  assign s1_in_range = (32'(s1_row_r) < ROWS) && (32'(s1_col_r) < COLS);

  assign cur_level = level_r[s1_key];
  assign cur_pend  = pend_r[s1_key];
  assign changed   = s1_raw_r != cur_level;
  assign pend_any  = changed || cur_pend;
  assign stamp_eff = changed ? s1_now_r : s1_stamp_r;
  assign age       = s1_now_r - stamp_eff;
  assign settled   = pend_any && (age >= 32'(deb_r));
  assign pend_nxt  = pend_any && !settled;
  assign stamp_wr  = s1_adv && s1_in_range && changed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_row_r <= in_row;
      s1_col_r <= in_col;
      s1_raw_r <= in_raw_pressed;
      s1_now_r <= in_now_ms;
    end
  end

  // stamp store, read registered with bypass of the write in the same cycle
  always_ff @(posedge clk) begin
    if (stamp_wr) begin
      stamp_mem[s1_key] <= s1_now_r;
    end
    if (in_fire) begin
      if (stamp_wr && (s1_key == in_key)) begin
        s1_stamp_r <= s1_now_r;
      end else begin
        s1_stamp_r <= stamp_mem[in_key];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
      pend_r  <= '0;
    end else if (s1_adv && s1_in_range) begin
      level_r[s1_key] <= s1_raw_r;
      pend_r[s1_key]  <= pend_nxt;
    end
  end

  // position map: rotation only for square matrices, flips after rotation
  assign rot_eff = SQUARE ? kmd_pkg::rot_t'(rot_r) : kmd_pkg::ROT_0;
  assign row6    = 6'(s1_row_r);
  assign col6    = 6'(s1_col_r);

  always_comb begin
    map_a = row6;
    map_b = col6;
    unique case (rot_eff)
      kmd_pkg::ROT_0: begin
        map_a = row6;
        map_b = col6;
      end
      kmd_pkg::ROT_90: begin
        map_a = col6;
        map_b = ROW_MAX - row6;
      end
      kmd_pkg::ROT_180: begin
        map_a = ROW_MAX - row6;
        map_b = COL_MAX - col6;
      end
      kmd_pkg::ROT_270: begin
        map_a = COL_MAX - col6;
        map_b = row6;
      end
    endcase
    if (inv_v_r) begin
      map_a = ROW_MAX - map_a;
    end
    if (inv_h_r) begin
      map_b = COL_MAX - map_b;
    end
  end

  assign out_valid_nxt = s1_adv && s1_in_range && settled;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_row_r     <= map_a[kmd_pkg::POS_W-1:0];
      out_col_r     <= map_b[kmd_pkg::POS_W-1:0];
      out_pressed_r <= s1_raw_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_row     = out_row_r;
  assign out_col     = out_col_r;
  assign out_pressed = out_pressed_r;

endmodule

`default_nettype wire

// ----- hdl/kmd_checker.sv -----
// ----------------------------------------------------------------------------
// kmd_checker
// port-level checks for the key matrix debouncer, attached by bind
// ----------------------------------------------------------------------------
`default_nettype none

`include "key_matrix_debouncer_defines.svh"

module kmd_checker #(
  parameter int unsigned ROWS = kmd_pkg::DEF_ROWS,
  parameter int unsigned COLS = kmd_pkg::DEF_COLS
) (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic [kmd_pkg::POS_W-1:0] in_row,
  input logic [kmd_pkg::POS_W-1:0] in_col,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [kmd_pkg::POS_W-1:0] out_row,
  input logic [kmd_pkg::POS_W-1:0] out_col,
  input logic                      out_pressed
);

  logic in_off_matrix;

  assign in_off_matrix = (32'(in_row) >= ROWS) || (32'(in_col) >= COLS);

  // a free result side never blocks the input
  `KMD_ASSERT_IMPL(a_ready_when_free, (!out_valid || out_ready), in_ready, "input blocked with free output")

  // a new result always comes from an item accepted at the input
  `KMD_ASSERT_IMPL(a_result_has_item, $rose(out_valid), $past(in_valid && in_ready, 2), "result without item")

  // a key outside the matrix never produces a result
  `KMD_ASSERT_IMPL(a_off_matrix_quiet, (in_valid && in_ready && in_off_matrix), ##2 !$rose(out_valid), "result for key outside matrix")

  // a stalled result holds its payload
  `KMD_ASSERT_NEXT(a_out_hold, (out_valid && !out_ready), (out_valid && $stable(out_row) && $stable(out_col) && $stable(out_pressed)), "stalled result changed")

endmodule

bind key_matrix_debouncer kmd_checker #(
  .ROWS(ROWS),
  .COLS(COLS)
) u_kmd_checker (.*);

`default_nettype wire
